### rtl/assert_macros.svh
// Assertion macros shared by the color matrix RTL.
// Depends on clk and rst_n being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define CMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define CMF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/cmf_pkg.sv
// Shared constants and types for the RGBA 4x5 color matrix filter.
// No dependencies.
package cmf_pkg;

  localparam int NUM_ROWS     = 4;
  localparam int COEF_BITS    = 16;
  localparam int CFG_BITS     = 64;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RED_ROW   = 3'd0,
    CFG_GREEN_ROW = 3'd1,
    CFG_BLUE_ROW  = 3'd2,
    CFG_ALPHA_ROW = 3'd3,
    CFG_BIASES    = 3'd4
  } cfg_idx_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic                azero;  // input alpha was zero
    logic [NUM_ROWS-1:0] pos;    // matrix sum of each row was positive
  } div_ctrl_t;

endpackage

### rtl/cmf_divider.sv
// Pipelined restoring divider, one quotient bit per stage, four rows sharing a divisor.
// Depends on cmf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmf_divider #(
  parameter int FRAC_BITS = 12,
  parameter int NUM_BITS  = 38
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NUM_BITS-1:0]   in_num [cmf_pkg::NUM_ROWS],
  input  logic [NUM_BITS-1:0]   in_den,
  input  cmf_pkg::div_ctrl_t    in_ctrl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS:0]    out_quo [cmf_pkg::NUM_ROWS],
  output cmf_pkg::div_ctrl_t    out_ctrl
);

  // bit FRAC_BITS first (saturation test), then the fraction bits downward
  localparam int NSTEP = FRAC_BITS + 1;
  localparam int NR    = cmf_pkg::NUM_ROWS;

  logic [NSTEP:0]         en;
  logic                   stage_v   [NSTEP];
  logic [NUM_BITS-1:0]    stage_rem [NSTEP][NR];
  logic [FRAC_BITS:0]     stage_quo [NSTEP][NR];
  logic [NUM_BITS-1:0]    stage_den [NSTEP];
  cmf_pkg::div_ctrl_t     stage_ctrl[NSTEP];

  assign en[NSTEP] = out_ready;
  assign in_ready  = en[0];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam int K = FRAC_BITS - i;

    logic                vin;
    logic [NUM_BITS-1:0] den_in;
    cmf_pkg::div_ctrl_t  ctrl_in;
    logic [NUM_BITS-1:0] rem_in  [NR];
    logic [FRAC_BITS:0]  quo_in  [NR];
    logic [NUM_BITS-1:0] rem_nxt [NR];
    logic [FRAC_BITS:0]  quo_nxt [NR];
    logic [NUM_BITS-1:0] den_sh;

    logic                v_r;
    logic [NUM_BITS-1:0] den_r;
    cmf_pkg::div_ctrl_t  ctrl_r;
    logic [NUM_BITS-1:0] rem_r [NR];
    logic [FRAC_BITS:0]  quo_r [NR];

    // stage input: module inputs or previous stage
    if (i == 0) begin : g_head
      assign vin     = in_valid;
      assign den_in  = in_den;
      assign ctrl_in = in_ctrl;
      assign rem_in  = in_num;
      assign quo_in  = '{default: '0};
    end else begin : g_link
      assign vin     = stage_v[i-1];
      assign den_in  = stage_den[i-1];
      assign ctrl_in = stage_ctrl[i-1];
      assign rem_in  = stage_rem[i-1];
      assign quo_in  = stage_quo[i-1];
    end

    // stage advances when empty or when the next one takes its item
    assign en[i] = !stage_v[i] || en[i+1];

    // one trial subtraction per row
    assign den_sh = den_in << K;
    always_comb begin
      for (int j = 0; j < NR; j++) begin
        if (rem_in[j] >= den_sh) begin
          rem_nxt[j] = rem_in[j] - den_sh;
          quo_nxt[j] = quo_in[j] | ((FRAC_BITS+1)'(1) << K);
        end else begin
          rem_nxt[j] = rem_in[j];
          quo_nxt[j] = quo_in[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en[i]) begin
        v_r <= vin;
      end
      if (en[i] && vin) begin
        den_r  <= den_in;
        ctrl_r <= ctrl_in;
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
      end
    end

    assign stage_v[i]    = v_r;
    assign stage_den[i]  = den_r;
    assign stage_ctrl[i] = ctrl_r;
    assign stage_rem[i]  = rem_r;
    assign stage_quo[i]  = quo_r;
  end

  assign out_valid = stage_v[NSTEP-1];
  assign out_quo   = stage_quo[NSTEP-1];
  assign out_ctrl  = stage_ctrl[NSTEP-1];

  // a stalled tail item stays put
  `CMF_ASSERT(a_tail_hold, stage_v[NSTEP-1] && !out_ready |=> stage_v[NSTEP-1], "divider tail item lost under stall")
  // nonzero alpha always gives a nonzero divisor
  `CMF_ASSERT(a_den_nonzero, stage_v[0] && !stage_ctrl[0].azero |-> stage_den[0] != '0, "zero divisor with nonzero alpha")
  // unsaturated quotient leaves a remainder below the divisor
  `CMF_ASSERT(a_rem_bound, stage_v[NSTEP-1] && !stage_ctrl[NSTEP-1].azero && !stage_quo[NSTEP-1][0][FRAC_BITS] |-> stage_rem[NSTEP-1][0] < stage_den[NSTEP-1], "row 0 remainder not reduced")

endmodule

### rtl/color_matrix_4x5_filter.sv
// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_red_in, in_green_in, in_blue_in, in_alpha_in
// out_      out_valid / out_ready   out_red_out, out_green_out, out_blue_out, out_alpha_out
// cfg_      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// One item per clock while out_ready stays high. The pipeline has 5 front stages,
// (COEF_FRAC_BITS + 1) divider stages and 3 back stages; the divider resolves
// one bit per stage for color / alpha.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity matrix
// with zero biases. When out_ready is low the output holds; earlier stages keep
// closing bubbles, so in_ready drops only once every stage holds an item.
// Top level of the RGBA 4x5 color matrix filter.
// Depends on cmf_pkg, cmf_divider and assert_macros.svh.
`include "assert_macros.svh"

module color_matrix_4x5_filter #(
  parameter int COEF_FRAC_BITS = 12,
  parameter int CHANNEL_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [CHANNEL_BITS-1:0]             in_red_in,
  input  logic [CHANNEL_BITS-1:0]             in_green_in,
  input  logic [CHANNEL_BITS-1:0]             in_blue_in,
  input  logic [CHANNEL_BITS-1:0]             in_alpha_in,
  // pixel out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CHANNEL_BITS-1:0]             out_red_out,
  output logic [CHANNEL_BITS-1:0]             out_green_out,
  output logic [CHANNEL_BITS-1:0]             out_blue_out,
  output logic [CHANNEL_BITS-1:0]             out_alpha_out,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cmf_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int C    = CHANNEL_BITS;
  localparam int F    = COEF_FRAC_BITS;
  localparam int CB   = cmf_pkg::COEF_BITS;
  localparam int NR   = cmf_pkg::NUM_ROWS;
  localparam int PW   = CB + C + 1;       // coefficient x channel
  localparam int SUMW = PW + 2;           // sum of three products
  localparam int UW   = PW + 3;           // plus bias x alpha
  localparam int AAW  = 2 * C;            // alpha squared
  localparam int TW   = CB + 2 * C + 1;   // coefficient x alpha squared
  localparam int SW   = UW + C + 1;       // full row sum S
  localparam int NW   = SW + 1;           // divider numerator
  localparam int AMW  = 2 * C;            // alpha x max code
  localparam int QW   = F + 1;            // clamped row value 0..2^F
  localparam int VAW  = QW + C;           // alpha value x max code
  localparam int AW2  = VAW + 1;
  localparam int EW   = 2 * QW + C + 1;   // color product x max code
  localparam int BW   = ((CB > QW) ? CB : QW) + 1;

  localparam logic [QW-1:0]  ONE_V = QW'(1) << F;
  localparam logic [EW-1:0]  HALF2 = EW'(1) << (2 * F - 1);
  localparam logic [AW2-1:0] HALF1 = AW2'(1) << (F - 1);

  // ---------------- configuration registers ----------------
  logic [cmf_pkg::CFG_BITS-1:0] coef_r [NR];
  logic [cmf_pkg::CFG_BITS-1:0] bias_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NR; j++) begin
        coef_r[j] <= cmf_pkg::CFG_BITS'(CB'(ONE_V)) << (CB * j);
      end
      bias_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cmf_pkg::CFG_RED_ROW:   coef_r[0] <= cfg_data;
        cmf_pkg::CFG_GREEN_ROW: coef_r[1] <= cfg_data;
        cmf_pkg::CFG_BLUE_ROW:  coef_r[2] <= cfg_data;
        cmf_pkg::CFG_ALPHA_ROW: coef_r[3] <= cfg_data;
        cmf_pkg::CFG_BIASES:    bias_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // signed fields, coefficient k of row j sits at bits 16k
  logic signed [CB-1:0] coef_f [NR][NR];
  logic signed [CB-1:0] bias_f [NR];
  logic [QW-1:0]        bias_clamp [NR];

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      for (int k = 0; k < NR; k++) begin
        coef_f[j][k] = coef_r[j][CB*k +: CB];
      end
      bias_f[j] = bias_r[CB*j +: CB];
      // zero-alpha result: bias clamped to 0..1
      if (bias_f[j] < 0) begin
        bias_clamp[j] = '0;
      end else if (BW'(bias_f[j]) > $signed({1'b0, BW'(ONE_V)})) begin
        bias_clamp[j] = ONE_V;
      end else begin
        bias_clamp[j] = QW'(bias_f[j]);
      end
    end
  end

  // ---------------- stage handshake ----------------
  logic v_f1_r, v_f2_r, v_f3_r, v_f4_r, v_f5_r;
  logic v_b1_r, v_b2_r, out_valid_r;
  logic en_f1, en_f2, en_f3, en_f4, en_f5, en_b1, en_b2, en_o;
  logic div_in_ready, div_out_valid;

  assign en_o  = !out_valid_r || out_ready;
  assign en_b2 = !v_b2_r || en_o;
  assign en_b1 = !v_b1_r || en_b2;
  assign en_f5 = !v_f5_r || div_in_ready;
  assign en_f4 = !v_f4_r || en_f5;
  assign en_f3 = !v_f3_r || en_f4;
  assign en_f2 = !v_f2_r || en_f3;
  assign en_f1 = !v_f1_r || en_f2;
  assign in_ready = en_f1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f1_r      <= 1'b0;
      v_f2_r      <= 1'b0;
      v_f3_r      <= 1'b0;
      v_f4_r      <= 1'b0;
      v_f5_r      <= 1'b0;
      v_b1_r      <= 1'b0;
      v_b2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_f1) v_f1_r      <= in_valid;
      if (en_f2) v_f2_r      <= v_f1_r;
      if (en_f3) v_f3_r      <= v_f2_r;
      if (en_f4) v_f4_r      <= v_f3_r;
      if (en_f5) v_f5_r      <= v_f4_r;
      if (en_b1) v_b1_r      <= div_out_valid;
      if (en_b2) v_b2_r      <= v_b1_r;
      if (en_o)  out_valid_r <= v_b2_r;
    end
  end

  // ---------------- F1: channel products ----------------
  logic [C-1:0]           chan_in [3];
  logic signed [PW-1:0]   p_nxt  [NR][3];
  logic signed [PW-1:0]   ba_nxt [NR];
  logic [AAW-1:0]         aa_nxt;
  logic signed [PW-1:0]   p_r    [NR][3];
  logic signed [PW-1:0]   ba_r   [NR];
  logic [AAW-1:0]         aa_r;
  logic [C-1:0]           a1_r;

  assign chan_in[0] = in_red_in;
  assign chan_in[1] = in_green_in;
  assign chan_in[2] = in_blue_in;

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      for (int k = 0; k < 3; k++) begin
        p_nxt[j][k] = PW'(coef_f[j][k]) * PW'($signed({1'b0, chan_in[k]}));
      end
      ba_nxt[j] = PW'(bias_f[j]) * PW'($signed({1'b0, in_alpha_in}));
    end
    aa_nxt = AAW'(in_alpha_in) * AAW'(in_alpha_in);
  end

  always_ff @(posedge clk) begin
    if (en_f1 && in_valid) begin
      p_r  <= p_nxt;
      ba_r <= ba_nxt;
      aa_r <= aa_nxt;
      a1_r <= in_alpha_in;
    end
  end

  // ---------------- F2: color sum, alpha-squared term ----------------
  logic signed [SUMW-1:0] sum3_nxt [NR];
  logic signed [TW-1:0]   t_nxt    [NR];
  logic signed [SUMW-1:0] sum3_r   [NR];
  logic signed [TW-1:0]   t2_r     [NR];
  logic signed [PW-1:0]   ba2_r    [NR];
  logic [C-1:0]           a2_r;

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      sum3_nxt[j] = SUMW'(p_r[j][0]) + SUMW'(p_r[j][1]) + SUMW'(p_r[j][2]);
      t_nxt[j]    = TW'(coef_f[j][3]) * TW'($signed({1'b0, aa_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (en_f2 && v_f1_r) begin
      sum3_r <= sum3_nxt;
      t2_r   <= t_nxt;
      ba2_r  <= ba_r;
      a2_r   <= a1_r;
    end
  end

  // ---------------- F3: add bias term ----------------
  logic signed [UW-1:0] u_nxt [NR];
  logic signed [UW-1:0] u_r   [NR];
  logic signed [TW-1:0] t3_r  [NR];
  logic [C-1:0]         a3_r;

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      u_nxt[j] = UW'(sum3_r[j]) + UW'(ba2_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_f3 && v_f2_r) begin
      u_r  <= u_nxt;
      t3_r <= t2_r;
      a3_r <= a2_r;
    end
  end

  // ---------------- F4: S = u * max code + t ----------------
  logic signed [SW-1:0] s_nxt [NR];
  logic [AMW-1:0]       am_nxt;
  logic signed [SW-1:0] s_r   [NR];
  logic [AMW-1:0]       am_r;
  logic                 az4_r;

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      s_nxt[j] = (SW'(u_r[j]) <<< C) - SW'(u_r[j]) + SW'(t3_r[j]);
    end
    am_nxt = (AMW'(a3_r) << C) - AMW'(a3_r);
  end

  always_ff @(posedge clk) begin
    if (en_f4 && v_f3_r) begin
      s_r   <= s_nxt;
      am_r  <= am_nxt;
      az4_r <= (a3_r == '0);
    end
  end

  // ---------------- F5: divider operands, rounding folded in ----------------
  logic [NW-1:0]      num_nxt [NR];
  cmf_pkg::div_ctrl_t ctrl_nxt;
  logic [NW-1:0]      num_r   [NR];
  logic [NW-1:0]      den_r;
  cmf_pkg::div_ctrl_t ctrl_r;

  always_comb begin
    ctrl_nxt.azero = az4_r;
    for (int j = 0; j < NR; j++) begin
      ctrl_nxt.pos[j] = !s_r[j][SW-1] && (s_r[j] != '0);
      num_nxt[j] = ctrl_nxt.pos[j] ? ({s_r[j], 1'b0} + NW'(am_r)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f5 && v_f4_r) begin
      num_r  <= num_nxt;
      den_r  <= NW'({am_r, 1'b0});
      ctrl_r <= ctrl_nxt;
    end
  end

  // ---------------- divider ----------------
  logic [QW-1:0]      div_quo [NR];
  cmf_pkg::div_ctrl_t div_ctrl;

  cmf_divider #(
    .FRAC_BITS (F),
    .NUM_BITS  (NW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_f5_r),
    .in_ready  (div_in_ready),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_ctrl   (ctrl_r),
    .out_valid (div_out_valid),
    .out_ready (en_b1),
    .out_quo   (div_quo),
    .out_ctrl  (div_ctrl)
  );

  // ---------------- B1: clamped row values ----------------
  logic [QW-1:0] v_nxt [NR];
  logic [QW-1:0] v_r   [NR];

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      if (div_ctrl.azero) begin
        v_nxt[j] = bias_clamp[j];
      end else if (!div_ctrl.pos[j]) begin
        v_nxt[j] = '0;
      end else if (div_quo[j][F]) begin
        v_nxt[j] = ONE_V;
      end else begin
        v_nxt[j] = div_quo[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b1 && div_out_valid) begin
      v_r <= v_nxt;
    end
  end

  // ---------------- B2: premultiply products ----------------
  logic [2*QW-1:0] prod_nxt [3];
  logic [2*QW-1:0] prod_r   [3];
  logic [VAW-1:0]  vam_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_nxt[j] = (2*QW)'(v_r[j]) * (2*QW)'(v_r[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b2 && v_b1_r) begin
      prod_r <= prod_nxt;
      vam_r  <= (VAW'(v_r[3]) << C) - VAW'(v_r[3]);
    end
  end

  // ---------------- B3: scale, round, output register ----------------
  logic [EW-1:0]  color_full [3];
  logic [AW2-1:0] alpha_full;
  logic [C-1:0]   out_red_r, out_green_r, out_blue_r, out_alpha_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      color_full[j] = (EW'(prod_r[j]) << C) - EW'(prod_r[j]) + HALF2;
    end
    alpha_full = AW2'(vam_r) + HALF1;
  end

  always_ff @(posedge clk) begin
    if (en_o && v_b2_r) begin
      out_red_r   <= color_full[0][2*F +: C];
      out_green_r <= color_full[1][2*F +: C];
      out_blue_r  <= color_full[2][2*F +: C];
      out_alpha_r <= alpha_full[F +: C];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;
  assign out_alpha_out = out_alpha_r;

  // transparent result carries no color
  `CMF_ASSERT(a_zero_alpha_clear, out_valid_r && (out_alpha_out == '0) |-> (out_red_out == '0) && (out_green_out == '0) && (out_blue_out == '0), "color left under zero alpha")
  // premultiplied color never exceeds alpha
  `CMF_ASSERT_NEVER(a_color_over_alpha, out_valid_r && ((out_red_out > out_alpha_out) || (out_green_out > out_alpha_out) || (out_blue_out > out_alpha_out)), "color above alpha")
  // front item waits for the divider, never dropped
  `CMF_ASSERT(a_front_hold, v_f5_r && !div_in_ready |=> v_f5_r, "front item lost while divider stalled")

endmodule

### dv/color_matrix_4x5_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for color_matrix_4x5_filter: random RGBA pixels under several
// matrix settings, each result checked against an in-bench fixed-point predictor.
// Depends on cmf_pkg and the color_matrix_4x5_filter RTL.

localparam int     FRAC_BITS    = 12;
localparam longint MAX_CODE     = 255;
localparam longint UNIT_LEVEL   = longint'(1) << FRAC_BITS;
localparam longint HALF_LEVEL   = longint'(1) << (FRAC_BITS - 1);
localparam longint HALF_PRODUCT = longint'(1) << (2 * FRAC_BITS - 1);

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
} rgba_t;

// Predicts filtered pixels and checks them in order against the block's output
class rgba_scoreboard;
  logic [63:0] coeff_rows [4];
  logic [63:0] biases;
  rgba_t       expected_q [$];
  int          mismatches;
  int          pixels_checked;

  function new();
    coeff_rows[0]  = 64'h0000_0000_0000_1000;
    coeff_rows[1]  = 64'h0000_0000_1000_0000;
    coeff_rows[2]  = 64'h0000_1000_0000_0000;
    coeff_rows[3]  = 64'h1000_0000_0000_0000;
    biases         = '0;
    mismatches     = 0;
    pixels_checked = 0;
  endfunction

  // Unused register indexes fall through and change nothing
  function void note_write(logic [cmf_pkg::CFG_IDX_BITS-1:0] index, logic [63:0] data);
    case (index)
      cmf_pkg::CFG_RED_ROW:   coeff_rows[0] = data;
      cmf_pkg::CFG_GREEN_ROW: coeff_rows[1] = data;
      cmf_pkg::CFG_BLUE_ROW:  coeff_rows[2] = data;
      cmf_pkg::CFG_ALPHA_ROW: coeff_rows[3] = data;
      cmf_pkg::CFG_BIASES:    biases = data;
      default: ;
    endcase
  endfunction

  function longint coef(logic [63:0] row, int k);
    return longint'($signed(row[16*k +: 16]));
  endfunction

  // Clamped matrix row result in 0..UNIT_LEVEL, rounded to nearest
  function longint row_level(int j, rgba_t px);
    longint bias, den, acc, lvl;
    bias = longint'($signed(biases[16*j +: 16]));
    if (px.alpha == 0) begin
      // zero alpha: color reads as zero, only the bias is left
      lvl = (bias < 0) ? 0 : bias;
    end else begin
      den = longint'(px.alpha) * MAX_CODE;
      acc = (coef(coeff_rows[j], 0) * longint'(px.red)
           + coef(coeff_rows[j], 1) * longint'(px.green)
           + coef(coeff_rows[j], 2) * longint'(px.blue)) * MAX_CODE
          + coef(coeff_rows[j], 3) * longint'(px.alpha) * longint'(px.alpha)
          + bias * den;
      lvl = (acc <= 0) ? 0 : (2 * acc + den) / (2 * den);
    end
    return (lvl > UNIT_LEVEL) ? UNIT_LEVEL : lvl;
  endfunction

  function logic [7:0] premultiply(longint color_lvl, longint alpha_lvl);
    longint t;
    t = (color_lvl * alpha_lvl * MAX_CODE + HALF_PRODUCT) >> (2 * FRAC_BITS);
    return t[7:0];
  endfunction

  function void note_pixel(rgba_t px);
    longint lr, lg, lb, la, ta;
    rgba_t  res;
    lr = row_level(0, px);
    lg = row_level(1, px);
    lb = row_level(2, px);
    la = row_level(3, px);
    ta = (la * MAX_CODE + HALF_LEVEL) >> FRAC_BITS;
    res.red   = premultiply(lr, la);
    res.green = premultiply(lg, la);
    res.blue  = premultiply(lb, la);
    res.alpha = ta[7:0];
    expected_q.push_back(res);
  endfunction

  function void check_pixel(rgba_t got);
    string lane_names [4] = '{"alpha", "blue", "green", "red"};
    rgba_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected pixel %h with nothing pending", $time, got);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    pixels_checked++;
    for (int k = 0; k < 4; k++) begin
      if (got[8*k +: 8] !== want[8*k +: 8]) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, lane_names[k],
                 want[8*k +: 8], got[8*k +: 8]);
        mismatches++;
      end
    end
  endfunction
endclass

module color_matrix_4x5_filter_tb;

  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int PRESSURE_PHASE  = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;   // longer than the filter pipeline
  localparam logic [cmf_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [cmf_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

  // corners, zero alpha, color above alpha, tiny alpha
  localparam rgba_t CORNER_PIXELS [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'hFF00_00FF,
    32'h00FF_00FF, 32'h0000_FFFF, 32'h8040_2080, 32'hFFFF_FF00,
    32'hC80A_6464, 32'h0101_0101, 32'h0100_0003, 32'hFFFF_FF01,
    32'h0000_0001, 32'h7F7F_7FFE, 32'h55AA_FFFF, 32'hFF00_FF80
  };

  typedef enum int {MIX_IDENTITY, MIX_ALL_MAX, MIX_ALL_MIN, MIX_RANDOM, MIX_WILD} matrix_mix_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  rgba_t                                in_px;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [7:0]                           out_red, out_green, out_blue, out_alpha;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [cmf_pkg::CFG_IDX_BITS-1:0]     cfg_index;
  logic [cmf_pkg::CFG_BITS-1:0]         cfg_data;

  rgba_scoreboard sb = new();

  bit tx_gaps;         // sender inserts idle cycles
  bit rx_stalls;       // receiver drops ready at random
  bit hold_off_req;    // one long receiver hold-off
  int pixels_sent;
  int zero_alpha_px;
  int above_alpha_px;
  int reg_writes;
  int settings_used;

  color_matrix_4x5_filter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_in     (in_px.red),
    .in_green_in   (in_px.green),
    .in_blue_in    (in_px.blue),
    .in_alpha_in   (in_px.alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red),
    .out_green_out (out_green),
    .out_blue_out  (out_blue),
    .out_alpha_out (out_alpha),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Moderate Q4.12 values most of the time, with the extremes mixed in
  function automatic logic [15:0] rand_coef();
    int v;
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: begin
        v = int'($urandom_range(12288)) - 6144;
        return v[15:0];
      end
    endcase
  endfunction

  // Mostly validly premultiplied, some with color above alpha
  function automatic rgba_t random_pixel();
    rgba_t px;
    int    roll;
    roll = $urandom_range(99);
    px.alpha = (roll < 10) ? 8'd0 : (roll < 25) ? 8'd255 : 8'($urandom_range(255, 1));
    if ($urandom_range(99) < 75) begin
      px.red   = 8'($urandom_range(px.alpha));
      px.green = 8'($urandom_range(px.alpha));
      px.blue  = 8'($urandom_range(px.alpha));
    end else begin
      px.red   = 8'($urandom);
      px.green = 8'($urandom);
      px.blue  = 8'($urandom);
    end
    return px;
  endfunction

  // Entered and left at a falling edge
  task automatic send_pixel(rgba_t px);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_px    = px;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
    pixels_sent++;
    if (px.alpha == 0) zero_alpha_px++;
    if (px.red > px.alpha || px.green > px.alpha || px.blue > px.alpha) above_alpha_px++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [cmf_pkg::CFG_IDX_BITS-1:0] index,
                           logic [cmf_pkg::CFG_BITS-1:0] value);
    cfg_index = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_write(index, value);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic load_matrix(matrix_mix_t mix);
    logic [cmf_pkg::CFG_BITS-1:0] rows [5];
    case (mix)
      MIX_IDENTITY: begin
        rows[0] = 64'h0000_0000_0000_1000;
        rows[1] = 64'h0000_0000_1000_0000;
        rows[2] = 64'h0000_1000_0000_0000;
        rows[3] = 64'h1000_0000_0000_0000;
        rows[4] = '0;
      end
      MIX_ALL_MAX: foreach (rows[i]) rows[i] = {4{16'h7FFF}};
      MIX_ALL_MIN: foreach (rows[i]) rows[i] = {4{16'h8000}};
      MIX_WILD:    foreach (rows[i]) rows[i] = {$urandom, $urandom};
      default:     foreach (rows[i]) rows[i] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endcase
    write_reg(cmf_pkg::CFG_RED_ROW, rows[0]);
    write_reg(cmf_pkg::CFG_GREEN_ROW, rows[1]);
    write_reg(cmf_pkg::CFG_BLUE_ROW, rows[2]);
    write_reg(cmf_pkg::CFG_ALPHA_ROW, rows[3]);
    write_reg(cmf_pkg::CFG_BIASES, rows[4]);
    // writes to unused indexes must leave the matrix alone
    if (mix == MIX_IDENTITY) begin
      write_reg(CFG_IDX_SPARE_LO, {$urandom, $urandom});
      write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom});
    end
    settings_used++;
  endtask

  // Receiver ready: random stalls, plus the one long hold-off on request
  initial begin : rx_driver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && rx_stalls) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel({out_red, out_green, out_blue, out_alpha});
  end

  // Ends the run if nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    matrix_mix_t mix;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_px     = '0;
    cfg_valid = 1'b0;
    cfg_index = cmf_pkg::CFG_RED_ROW;
    cfg_data  = '0;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners under the reset matrix
    foreach (CORNER_PIXELS[i]) send_pixel(CORNER_PIXELS[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      mix = (phase == 0) ? MIX_IDENTITY :
            (phase == 1) ? MIX_ALL_MAX  :
            (phase == 2) ? MIX_ALL_MIN  :
            (phase % 4 == 3) ? MIX_WILD : MIX_RANDOM;
      load_matrix(mix);
      tx_gaps   = (phase % 3 != 0);
      rx_stalls = (phase % 2 == 1);
      // long receiver hold-off while the sender keeps pushing
      if (phase == PRESSURE_PHASE) begin
        tx_gaps      = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels (%0d zero alpha, %0d color above alpha) over %0d matrix settings",
             pixels_sent, zero_alpha_px, above_alpha_px, settings_used);
    $display("%0d register writes, %0d results compared, one %0d-cycle output hold-off",
             reg_writes, sb.pixels_checked, HOLD_OFF_CYCLES);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cmf_pkg.sv
rtl/cmf_divider.sv
rtl/color_matrix_4x5_filter.sv
dv/color_matrix_4x5_filter_tb.sv
